// ===== sv/ema_thr_pkg.sv =====
// shared types and constants for the ema filter with timed threshold
package ema_thr_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAX_SHIFT   = 16;
  localparam int ACC_BITS    = SAMPLE_BITS + MAX_SHIFT + 1;
  localparam int SHIFT_W     = 5;
  localparam int VALUE_W     = 32;
  localparam int TIME_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int IN_W        = VALUE_W + TIME_W;
  localparam int OUT_W       = 40;

  localparam logic [ADDR_W-1:0] ADDR_SHIFT     = 5'h00;
  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 5'h04;
  localparam logic [ADDR_W-1:0] ADDR_INVERT    = 5'h08;
  localparam logic [ADDR_W-1:0] ADDR_DWELL     = 5'h0c;
  localparam logic [ADDR_W-1:0] ADDR_ENABLE    = 5'h10;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic               shift_zero;
    logic [VALUE_W-1:0] threshold;
    logic               invert;
    logic [TIME_W-1:0]  dwell;
    logic               enable;
  } cfg_t;

endpackage

// ===== sv/ema_filter_with_timed_threshold.sv =====
// top level of the ema filter with timed threshold
//
// input stream s_*: one request per sample, tdata carries the signed sample
// and its 32-bit timestamp. output stream m_*: one result per request with
// the filtered value and the detection flags, in request order.
// configuration goes through the apb port: shift, threshold, invert,
// dwell time and comparator enable at byte addresses 0x00 to 0x10; write
// only while no request is in flight. m_tvalid follows s1_valid through the
// result register. throughput is one request per cycle while m_tready is
// high: the accumulator update runs in the filter stage and the scaling,
// compare and dwell timing in the output stage. when m_tready is low the
// result register holds and the filter stage still takes one more request;
// after that s_tready drops until the output drains.
// reset (rst, synchronous) clears the accumulator, the detection state,
// the dwell timer and the configuration registers, and empties both stages.
module ema_filter_with_timed_threshold (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ema_thr_pkg::IN_W-1:0]   s_tdata,   // sample, now_time
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ema_thr_pkg::OUT_W-1:0]  m_tdata,   // filtered_value, detected,
                                                    // det_rise, det_fall,
                                                    // det_flip, zero pad
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ema_thr_pkg::ADDR_W-1:0] paddr,
  input  logic [ema_thr_pkg::DATA_W-1:0] pwdata,
  output logic [ema_thr_pkg::DATA_W-1:0] prdata,
  output logic                           pready
);
  import ema_thr_pkg::*;

  cfg_t                       cfg;
  logic                       s1_valid;
  logic                       s1_ready;
  logic signed [ACC_BITS-1:0] acc;
  logic [TIME_W-1:0]          s1_now;
  logic [VALUE_W-1:0]         filtered_value;
  logic                       detected;
  logic                       det_rise;
  logic                       det_fall;
  logic                       det_flip;

  ema_thr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ema_thr_filt u_filt (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sample   (s_tdata[SAMPLE_BITS-1:0]),
    .now_time (s_tdata[VALUE_W +: TIME_W]),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .acc      (acc),
    .s1_now   (s1_now)
  );

  ema_thr_det u_det (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .s1_valid       (s1_valid),
    .s1_ready       (s1_ready),
    .acc            (acc),
    .s1_now         (s1_now),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .filtered_value (filtered_value),
    .detected       (detected),
    .det_rise       (det_rise),
    .det_fall       (det_fall),
    .det_flip       (det_flip)
  );

  assign m_tdata = {{(OUT_W - VALUE_W - 4){1'b0}}, det_flip, det_fall,
                    det_rise, detected, filtered_value};

endmodule

// ===== sv/ema_thr_cfg.sv =====
// configuration registers behind the apb port
module ema_thr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ema_thr_pkg::ADDR_W-1:0] paddr,
  input  logic [ema_thr_pkg::DATA_W-1:0] pwdata,
  output logic [ema_thr_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output ema_thr_pkg::cfg_t              cfg
);
  import ema_thr_pkg::*;

  logic [SHIFT_W-1:0] shift_k;
  logic [VALUE_W-1:0] threshold;
  logic               invert_compare;
  logic [TIME_W-1:0]  dwell_time;
  logic               comparator_enable;
  logic               wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_k           <= '0;
      threshold         <= '0;
      invert_compare    <= 1'b0;
      dwell_time        <= '0;
      comparator_enable <= 1'b0;
    end else if (wr) begin
      case (paddr)
        ADDR_SHIFT:     shift_k           <= pwdata[SHIFT_W-1:0];
        ADDR_THRESHOLD: threshold         <= pwdata[VALUE_W-1:0];
        ADDR_INVERT:    invert_compare    <= pwdata[0];
        ADDR_DWELL:     dwell_time        <= pwdata[TIME_W-1:0];
        ADDR_ENABLE:    comparator_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr)
      ADDR_SHIFT:     prdata[SHIFT_W-1:0] = shift_k;
      ADDR_THRESHOLD: prdata[VALUE_W-1:0] = threshold;
      ADDR_INVERT:    prdata[0]           = invert_compare;
      ADDR_DWELL:     prdata[TIME_W-1:0]  = dwell_time;
      ADDR_ENABLE:    prdata[0]           = comparator_enable;
      default:        prdata              = '0;
    endcase
  end

  // oversized shift acts as the maximum
  always_comb begin
    if (shift_k > SHIFT_W'(MAX_SHIFT)) begin
      cfg.shift = SHIFT_W'(MAX_SHIFT);
    end else begin
      cfg.shift = shift_k;
    end
    cfg.shift_zero = (shift_k == '0);
    cfg.threshold  = threshold;
    cfg.invert     = invert_compare;
    cfg.dwell      = dwell_time;
    cfg.enable     = comparator_enable;
  end

endmodule

// ===== sv/ema_thr_filt.sv =====
// filter stage: accumulator update on each accepted request
module ema_thr_filt (
  input  logic                                     clk,
  input  logic                                     rst,
  input  ema_thr_pkg::cfg_t                        cfg,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [ema_thr_pkg::SAMPLE_BITS-1:0]      sample,
  input  logic [ema_thr_pkg::TIME_W-1:0]           now_time,
  output logic                                     s1_valid,
  input  logic                                     s1_ready,
  output logic signed [ema_thr_pkg::ACC_BITS-1:0]  acc,
  output logic [ema_thr_pkg::TIME_W-1:0]           s1_now
);
  import ema_thr_pkg::*;

  logic signed [ACC_BITS-1:0] acc_next;
  logic signed [ACC_BITS-1:0] shifted;
  logic signed [ACC_BITS:0]   sum;
  logic signed [ACC_BITS:0]   sample_ext;
  logic                       load;

  assign in_ready = !s1_valid || s1_ready;
  assign load = in_valid && in_ready;

  always_comb begin
    shifted    = acc >>> cfg.shift;
    sample_ext = $signed({{(ACC_BITS + 1 - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample});
    sum = $signed({acc[ACC_BITS-1], acc}) - $signed({shifted[ACC_BITS-1], shifted})
          + sample_ext;
    if (cfg.shift_zero) begin
      acc_next = sample_ext[ACC_BITS-1:0];
    end else if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      // saturate to the accumulator range
      acc_next = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                               : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      acc_next = sum[ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (load) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_now <= now_time;
    end
  end

endmodule

// ===== sv/ema_thr_det.sv =====
// output stage: scaling, timed threshold detection and result register
module ema_thr_det (
  input  logic                                     clk,
  input  logic                                     rst,
  input  ema_thr_pkg::cfg_t                        cfg,
  input  logic                                     s1_valid,
  output logic                                     s1_ready,
  input  logic signed [ema_thr_pkg::ACC_BITS-1:0]  acc,
  input  logic [ema_thr_pkg::TIME_W-1:0]           s1_now,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [ema_thr_pkg::VALUE_W-1:0]          filtered_value,
  output logic                                     detected,
  output logic                                     det_rise,
  output logic                                     det_fall,
  output logic                                     det_flip
);
  import ema_thr_pkg::*;

  logic signed [ACC_BITS-1:0]    scaled;
  logic signed [SAMPLE_BITS-1:0] filt;
  logic signed [VALUE_W-1:0]     filt_ext;
  logic                          oor;
  logic                          timed_ok;
  logic                          det_next;
  logic [TIME_W-1:0]             elapsed;
  logic                          detection_flag;
  logic                          time_started;
  logic [TIME_W-1:0]             last_in_range_time;
  logic                          step;

  assign s1_ready = !out_valid || out_ready;
  assign step = s1_valid && s1_ready;

  always_comb begin
    scaled = acc >>> cfg.shift;
    if (scaled[ACC_BITS-1:SAMPLE_BITS-1] == '0 || scaled[ACC_BITS-1:SAMPLE_BITS-1] == '1) begin
      filt = scaled[SAMPLE_BITS-1:0];
    end else begin
      filt = scaled[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    filt_ext = $signed({{(VALUE_W + 1 - SAMPLE_BITS){filt[SAMPLE_BITS-1]}},
                        filt[SAMPLE_BITS-2:0]});
    oor = cfg.invert ? (filt_ext < $signed(cfg.threshold))
                     : (filt_ext > $signed(cfg.threshold));
    elapsed = s1_now - last_in_range_time;
    // first enabled request starts the clock at zero
    timed_ok = time_started ? (elapsed >= cfg.dwell) : (cfg.dwell == '0);
    det_next = oor && timed_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      detection_flag     <= 1'b0;
      time_started       <= 1'b0;
      last_in_range_time <= '0;
    end else begin
      if (s1_ready) begin
        out_valid <= s1_valid;
      end
      if (step && cfg.enable) begin
        detection_flag <= det_next;
        time_started   <= 1'b1;
        if (!time_started || !oor) begin
          last_in_range_time <= s1_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      filtered_value <= filt_ext;
      detected       <= cfg.enable && det_next;
      det_rise       <= cfg.enable && det_next && !detection_flag;
      det_fall       <= cfg.enable && !det_next && detection_flag;
      det_flip       <= cfg.enable && (det_next != detection_flag);
    end
  end

endmodule

// ===== verif/ema_filter_with_timed_threshold_test.sv =====
// self-checking stream test of the ema filter with timed threshold detection
module ema_filter_with_timed_threshold_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ema_thr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1525;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 5'h14;

  typedef struct packed {
    logic               det_flip;
    logic               det_fall;
    logic               det_rise;
    logic               detected;
    logic [VALUE_W-1:0] filtered_value;
  } reading_t;

  class ema_tracker;
    logic [SHIFT_W-1:0] shift;
    int                 threshold;
    bit                 invert;
    int unsigned        dwell;
    bit                 enable;
    longint             acc;
    bit                 detecting;
    bit                 timing;
    int unsigned        in_range_since;
    reading_t           awaited[$];
    int                 mismatches;
    int                 checked;
    int                 rises;

    function new();
      shift = '0;
      threshold = 0;
      invert = 0;
      dwell = 0;
      enable = 0;
      acc = 0;
      detecting = 0;
      timing = 0;
      in_range_since = 0;
      mismatches = 0;
      checked = 0;
      rises = 0;
    endfunction

    function longint saturate(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      case (addr)
        ADDR_SHIFT:     shift = data[SHIFT_W-1:0];
        ADDR_THRESHOLD: threshold = data;
        ADDR_INVERT:    invert = data[0];
        ADDR_DWELL:     dwell = data;
        ADDR_ENABLE:    enable = data[0];
        default: ;
      endcase
    endfunction

    function void take_sample(int sample, int unsigned now);
      int          k;
      longint      filt;
      bit          beyond;
      bit          was;
      int unsigned elapsed;
      reading_t    r;
      k = (shift > MAX_SHIFT) ? MAX_SHIFT : shift;
      if (k == 0) begin
        acc = sample;
        filt = sample;
      end else begin
        acc = saturate(acc - (acc >>> k) + sample, ACC_BITS);
        filt = saturate(acc >>> k, SAMPLE_BITS);
      end
      r = '0;
      r.filtered_value = filt[VALUE_W-1:0];
      if (enable) begin
        if (!timing) begin
          in_range_since = now;
          timing = 1;
        end
        beyond = invert ? (filt < threshold) : (filt > threshold);
        if (!beyond) in_range_since = now;
        was = detecting;
        elapsed = now - in_range_since;
        detecting = beyond && (elapsed >= dwell);
        r.detected = detecting;
        r.det_rise = detecting && !was;
        r.det_fall = was && !detecting;
        r.det_flip = was != detecting;
        if (r.det_rise) rises++;
      end
      awaited.push_back(r);
    endfunction

    function void check_reading(logic [OUT_W-1:0] data);
      reading_t got;
      reading_t want;
      got = data[$bits(reading_t)-1:0];
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("reading %h arrived with nothing awaited", got);
        return;
      end
      want = awaited.pop_front();
      if (got.filtered_value !== want.filtered_value || got.detected !== want.detected ||
          got.det_rise !== want.det_rise || got.det_fall !== want.det_fall ||
          got.det_flip !== want.det_flip) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading %0d: expected value %0d det %b rise %b fall %b chg %b", checked,
                   $signed(want.filtered_value), want.detected, want.det_rise,
                   want.det_fall, want.det_flip);
        if (mismatches <= 10)
          $display("reading %0d: actual   value %0d det %b rise %b fall %b chg %b", checked,
                   $signed(got.filtered_value), got.detected, got.det_rise,
                   got.det_fall, got.det_flip);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;   // sample, now_time
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;        // filtered_value, detected, det_rise,
                                     // det_fall, det_flip, zero pad
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ema_tracker ema = new();
  bit         steady = 1'b0;
  int         stalled = 0;
  int         sent = 0;
  int         settings = 0;

  ema_filter_with_timed_threshold dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ema.check_reading(m_tdata);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) stalled <= 0;
    else stalled <= stalled + 1;
    if (stalled == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ema.write_reg(addr, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_filter(logic [SHIFT_W-1:0] sh, logic [DATA_W-1:0] thr, bit inv,
                            logic [DATA_W-1:0] dw, bit en);
    apb_write(ADDR_SHIFT, DATA_W'(sh));
    apb_write(ADDR_THRESHOLD, thr);
    apb_write(ADDR_INVERT, DATA_W'(inv));
    apb_write(ADDR_DWELL, dw);
    apb_write(ADDR_ENABLE, DATA_W'(en));
    settings++;
  endtask

  task automatic send_item(logic [VALUE_W-1:0] sample, logic [TIME_W-1:0] now);
    while (!steady && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {now, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ema.take_sample(sample, now);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (ema.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [SHIFT_W-1:0] sh;
    logic [DATA_W-1:0]  thr;
    logic [DATA_W-1:0]  dw;
    logic [TIME_W-1:0]  t;
    logic [VALUE_W-1:0] smp;
    longint             level;
    longint             offset;
    int                 phase;
    int                 len;
    int                 run;
    int                 random_sent;
    bit                 wide;
    bit                 above;

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset settings: pass-through, comparator off
    send_item(32'h7fffffff, 32'h00000000);
    send_item(32'h80000000, 32'hffffffff);
    send_item(32'h00000000, 32'haaaaaaaa);
    send_item(32'hffffffff, 32'h55555555);
    drain();

    // first enabled item, immediate detection
    set_filter(0, 100, 0, 0, 1);
    send_item(50, 10);
    send_item(200, 11);
    send_item(200, 12);
    send_item(50, 13);
    drain();

    // inverted compare with dwell across the time wrap
    set_filter(0, 0, 1, 10, 1);
    send_item(0, 32'hfffffff8);
    send_item(-5, 32'hfffffffc);
    send_item(-5, 32'h00000001);
    send_item(-5, 32'h00000002);
    send_item(5, 32'h00000003);
    drain();

    // grow a large accumulator, then shorten the shift
    set_filter(MAX_SHIFT, 32'h7fffffff, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_item(32'h7fffffff, 100 + i);
    drain();
    set_filter(1, 32'h7fffffff, 0, 0, 1);
    send_item(32'h7fffffff, 200);
    send_item(32'h7fffffff, 201);
    drain();

    // oversized shift, extreme threshold and dwell, ignored register write
    apb_write(ADDR_UNUSED, 32'hffffffff);
    set_filter(5'd31, 32'h80000000, 1, 32'hffffffff, 1);
    send_item(32'h80000000, 300);
    send_item(32'h80000000, 301);
    send_item(32'h80000000, 302);

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(4))
        0: sh = '0;
        1: sh = SHIFT_W'(1);
        2: sh = SHIFT_W'(MAX_SHIFT);
        3: sh = SHIFT_W'($urandom_range(MAX_SHIFT + 1, 31));
        default: sh = SHIFT_W'($urandom_range(2, 8));
      endcase
      case ($urandom_range(5))
        0: thr = 32'h7fffffff;
        1: thr = 32'h80000000;
        2: thr = $urandom;
        default: thr = $urandom_range(2000) - 1000;
      endcase
      case ($urandom_range(4))
        0: dw = 0;
        1: dw = 32'hffffffff;
        2: dw = $urandom;
        default: dw = $urandom_range(1, 40);
      endcase
      set_filter(sh, thr, 1'($urandom_range(1)), dw, $urandom_range(9) != 0);
      steady = (phase == 3);
      len = $urandom_range(40, 160);
      wide = ($urandom_range(3) == 0);
      t = ($urandom_range(1) == 1) ? 32'hffffff00 : $urandom;
      above = 1'($urandom_range(1));
      run = $urandom_range(1, 30);
      for (int i = 0; i < len && random_sent < RANDOM_ITEMS; i++) begin
        if (phase == 2 && i == len / 2) drain();
        if (run == 0) begin
          above = !above;
          run = $urandom_range(1, 30);
        end
        run--;
        if (wide) begin
          smp = $urandom;
        end else begin
          offset = $urandom_range(1, 500);
          level = above ? longint'($signed(thr)) + offset : longint'($signed(thr)) - offset;
          smp = VALUE_W'(ema.saturate(level, VALUE_W));
        end
        t = ($urandom_range(49) == 0) ? $urandom : t + $urandom_range(0, 6);
        send_item(smp, t);
        random_sent++;
      end
      phase++;
    end
    steady = 1'b0;
    drain();

    $display("%0d samples sent over %0d filter settings, %0d readings checked",
             sent, settings, ema.checked);
    $display("%0d detections raised, %0d mismatches", ema.rises, ema.mismatches);
    if (ema.mismatches == 0 && ema.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
